### rtl/core/cursor_linked_list_engine_core_defines.svh
// assertion macros for the cursor linked list engine core
`ifndef CURSOR_LINKED_LIST_ENGINE_CORE_DEFINES_SVH
`define CURSOR_LINKED_LIST_ENGINE_CORE_DEFINES_SVH
`ifndef SYNTH
`define CLLEC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CLLEC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CLLEC_ASSERT_IMPL(label, ante, cons)
`define CLLEC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/core/cllec_pkg.sv
package cllec_pkg;

  localparam int NODE_DEPTH = 256;
  localparam int ADDR_W = $clog2(NODE_DEPTH);
  localparam int HANDLE_W = ADDR_W + 1;
  localparam int DATA_W = 32;
  localparam logic [HANDLE_W-1:0] NONE_H = HANDLE_W'(NODE_DEPTH);
  // up link value of a node that sits on the free chain
  localparam logic [HANDLE_W-1:0] FREE_MARK = '1;

  typedef enum logic [3:0] {
    OP_PUSH      = 4'd0,
    OP_POP       = 4'd1,
    OP_TOP       = 4'd2,
    OP_BOTTOM    = 4'd3,
    OP_DOWN      = 4'd4,
    OP_UP        = 4'd5,
    OP_INS_BELOW = 4'd6,
    OP_INS_ABOVE = 4'd7,
    OP_DELETE    = 4'd8,
    OP_GOTO      = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_ELEM = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_POS     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_FREE,
    S_RD_NODE,
    S_LATCH,
    S_WR1,
    S_WR2,
    S_RD_CUR,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_PUSH,
    ACT_DELETE,
    ACT_INS_BELOW,
    ACT_INS_ABOVE
  } act_t;

  typedef struct packed {
    logic [3:0]          opcode;
    logic [DATA_W-1:0]   item_data;
    logic                move_up_after;
    logic [HANDLE_W-1:0] target_handle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [DATA_W-1:0]   removed_data;
    logic                cursor_valid;
    logic [HANDLE_W-1:0] cursor_handle;
    logic [DATA_W-1:0]   cursor_data;
    logic [HANDLE_W-1:0] element_count;
  } out_item_t;

  typedef struct packed {
    logic                data_we;
    logic [ADDR_W-1:0]   data_wa;
    logic [DATA_W-1:0]   data_wd;
    logic [ADDR_W-1:0]   data_ra;
    logic                up_we;
    logic [ADDR_W-1:0]   up_wa;
    logic [HANDLE_W-1:0] up_wd;
    logic [ADDR_W-1:0]   up_ra;
    logic                dn_we;
    logic [ADDR_W-1:0]   dn_wa;
    logic [HANDLE_W-1:0] dn_wd;
    logic [ADDR_W-1:0]   dn_ra;
  } mem_req_t;

  typedef struct packed {
    logic [DATA_W-1:0]   data;
    logic [HANDLE_W-1:0] up;
    logic [HANDLE_W-1:0] dn;
  } mem_rd_t;

  function automatic logic is_node(input logic [HANDLE_W-1:0] h);
    return ~h[HANDLE_W-1];
  endfunction

endpackage

### rtl/core/cursor_linked_list_engine_core.sv
// Doubly linked stack with a cursor over a 256-node pool. Each item is one
// operation and gives exactly one result item. An item runs through a
// sequence of states from acceptance until the engine takes the next one:
// reading the free chain head and the links of the working node (single
// read port per node memory, registered read data), the states WR1 and
// WR2 for the link updates, and a read of the cursor's data. in_stall is
// high for the whole sequence. A finished result sits in an output register,
// so the next item is accepted while it waits; the engine only holds at the
// end of the following item if that register is still full.
`include "cursor_linked_list_engine_core_defines.svh"

module cursor_linked_list_engine_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cllec_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cllec_pkg::out_item_t out_item
);

  cllec_pkg::mem_req_t  req;
  cllec_pkg::mem_rd_t   rd;
  cllec_pkg::out_item_t res;
  logic                 res_valid;
  logic                 res_ready;

  cllec_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .req       (req),
    .rd        (rd)
  );

  cllec_node_mem u_mem (
    .clk (clk),
    .req (req),
    .rd  (rd)
  );

  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_item <= res;
    end
  end

  `CLLEC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `CLLEC_ASSERT_IMPL(a_count_range, out_valid, out_item.element_count <= cllec_pkg::NONE_H)
  `CLLEC_ASSERT_IMPL(a_no_cursor_fields, out_valid && !out_item.cursor_valid, (out_item.cursor_handle == cllec_pkg::NONE_H) && (out_item.cursor_data == '0))

endmodule

### rtl/core/cllec_node_mem.sv
module cllec_node_mem (
  input  logic                clk,
  input  cllec_pkg::mem_req_t req,
  output cllec_pkg::mem_rd_t  rd
);

  logic [cllec_pkg::DATA_W-1:0]   data_mem [cllec_pkg::NODE_DEPTH];
  logic [cllec_pkg::HANDLE_W-1:0] up_mem   [cllec_pkg::NODE_DEPTH];
  logic [cllec_pkg::HANDLE_W-1:0] dn_mem   [cllec_pkg::NODE_DEPTH];

  logic [cllec_pkg::DATA_W-1:0]   data_q;
  logic [cllec_pkg::HANDLE_W-1:0] up_q;
  logic [cllec_pkg::HANDLE_W-1:0] dn_q;

  always_ff @(posedge clk) begin
    if (req.data_we) begin
      data_mem[req.data_wa] <= req.data_wd;
    end
    data_q <= data_mem[req.data_ra];
  end

  always_ff @(posedge clk) begin
    if (req.up_we) begin
      up_mem[req.up_wa] <= req.up_wd;
    end
    up_q <= up_mem[req.up_ra];
  end

  always_ff @(posedge clk) begin
    if (req.dn_we) begin
      dn_mem[req.dn_wa] <= req.dn_wd;
    end
    dn_q <= dn_mem[req.dn_ra];
  end

  assign rd = '{data: data_q, up: up_q, dn: dn_q};

endmodule

### rtl/core/cllec_ctrl.sv
module cllec_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cllec_pkg::in_item_t  in_item,
  output logic                 res_valid,
  input  logic                 res_ready,
  output cllec_pkg::out_item_t res,
  output cllec_pkg::mem_req_t  req,
  input  cllec_pkg::mem_rd_t   rd
);

  localparam int AW = cllec_pkg::ADDR_W;
  localparam int HW = cllec_pkg::HANDLE_W;

  cllec_pkg::state_t  state, state_next;
  cllec_pkg::act_t    act, l_act;
  cllec_pkg::status_t status_r, l_status;

  logic [3:0]                   opc;
  logic [cllec_pkg::DATA_W-1:0] item_data;
  logic                         go_up;
  logic [HW-1:0]                target;

  logic [HW-1:0] top, bottom, cur, count, free_head, bump;
  logic [HW-1:0] free_link;

  logic [AW-1:0] h_reg, c_reg;
  logic [HW-1:0] up_reg, dn_reg, old_top, old_free;
  logic [cllec_pkg::DATA_W-1:0] removed_r, l_removed;

  logic [HW-1:0] xh, take_h, free_after, l_cur;
  logic          pool_ok;

  // node the operation works on: the top for pop, the target for goto, else the cursor
  assign xh = (opc == cllec_pkg::OP_POP) ? top :
              (opc == cllec_pkg::OP_GOTO) ? target : cur;
  assign take_h = cllec_pkg::is_node(free_head) ? free_head : bump;
  assign pool_ok = cllec_pkg::is_node(free_head) || cllec_pkg::is_node(bump);
  assign free_after = cllec_pkg::is_node(free_link) ? free_link : cllec_pkg::NONE_H;

  always_comb begin
    state_next = state;
    unique case (state)
      cllec_pkg::S_IDLE:    if (in_valid) state_next = cllec_pkg::S_RD_FREE;
      cllec_pkg::S_RD_FREE: state_next = cllec_pkg::S_RD_NODE;
      cllec_pkg::S_RD_NODE: state_next = cllec_pkg::S_LATCH;
      cllec_pkg::S_LATCH:   state_next = cllec_pkg::S_WR1;
      cllec_pkg::S_WR1:     state_next = cllec_pkg::S_WR2;
      cllec_pkg::S_WR2:     state_next = cllec_pkg::S_RD_CUR;
      cllec_pkg::S_RD_CUR:  state_next = cllec_pkg::S_DONE;
      cllec_pkg::S_DONE:    if (res_ready) state_next = cllec_pkg::S_IDLE;
      default:              state_next = cllec_pkg::S_IDLE;
    endcase
  end

  // decode of the operation once the node links are back from memory
  always_comb begin
    l_act = cllec_pkg::ACT_NONE;
    l_status = cllec_pkg::STAT_OK;
    l_cur = cur;
    l_removed = '0;
    unique case (cllec_pkg::op_t'(opc))
      cllec_pkg::OP_PUSH: begin
        if (pool_ok) begin
          l_act = cllec_pkg::ACT_PUSH;
          l_cur = take_h;
        end else l_status = cllec_pkg::STAT_FULL;
      end
      cllec_pkg::OP_POP: begin
        if (cllec_pkg::is_node(top)) begin
          l_act = cllec_pkg::ACT_DELETE;
          l_cur = rd.dn;
          l_removed = rd.data;
        end else begin
          l_cur = top;
          l_status = cllec_pkg::STAT_NO_ELEM;
        end
      end
      cllec_pkg::OP_TOP:    l_cur = top;
      cllec_pkg::OP_BOTTOM: l_cur = bottom;
      cllec_pkg::OP_DOWN: begin
        if (cllec_pkg::is_node(cur)) l_cur = rd.dn;
        else l_status = cllec_pkg::STAT_NO_ELEM;
      end
      cllec_pkg::OP_UP: begin
        if (cllec_pkg::is_node(cur)) l_cur = rd.up;
        else l_status = cllec_pkg::STAT_NO_ELEM;
      end
      cllec_pkg::OP_INS_BELOW, cllec_pkg::OP_INS_ABOVE: begin
        if (!cllec_pkg::is_node(cur) && cllec_pkg::is_node(top)) begin
          l_status = cllec_pkg::STAT_POS;
        end else if (!pool_ok) begin
          l_status = cllec_pkg::STAT_FULL;
        end else if (!cllec_pkg::is_node(cur)) begin
          l_act = cllec_pkg::ACT_PUSH;
        end else if (opc == cllec_pkg::OP_INS_BELOW) begin
          l_act = cllec_pkg::ACT_INS_BELOW;
        end else begin
          l_act = cllec_pkg::ACT_INS_ABOVE;
        end
        if (l_act != cllec_pkg::ACT_NONE) l_cur = take_h;
      end
      cllec_pkg::OP_DELETE: begin
        if (cllec_pkg::is_node(cur)) begin
          l_act = cllec_pkg::ACT_DELETE;
          l_cur = go_up ? rd.up : rd.dn;
          l_removed = rd.data;
        end else l_status = cllec_pkg::STAT_NO_ELEM;
      end
      cllec_pkg::OP_GOTO: begin
        // a node is in the list if it was ever handed out and is not on the free chain
        if (!cllec_pkg::is_node(target)) begin
          l_cur = cllec_pkg::NONE_H;
        end else if (target < bump && rd.up != cllec_pkg::FREE_MARK) begin
          l_cur = target;
        end else begin
          l_cur = cllec_pkg::NONE_H;
          l_status = cllec_pkg::STAT_NO_ELEM;
        end
      end
      default: l_cur = cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cllec_pkg::S_IDLE;
      act <= cllec_pkg::ACT_NONE;
      top <= cllec_pkg::NONE_H;
      bottom <= cllec_pkg::NONE_H;
      cur <= cllec_pkg::NONE_H;
      count <= '0;
      free_head <= cllec_pkg::NONE_H;
      bump <= '0;
    end else begin
      state <= state_next;
      if (state == cllec_pkg::S_IDLE && in_valid) begin
        opc <= in_item.opcode;
        item_data <= in_item.item_data;
        go_up <= in_item.move_up_after;
        target <= in_item.target_handle;
      end
      if (state == cllec_pkg::S_RD_NODE) begin
        free_link <= rd.dn;
      end
      if (state == cllec_pkg::S_LATCH) begin
        act <= l_act;
        status_r <= l_status;
        cur <= l_cur;
        removed_r <= l_removed;
        h_reg <= take_h[AW-1:0];
        c_reg <= xh[AW-1:0];
        up_reg <= rd.up;
        dn_reg <= rd.dn;
        old_top <= top;
        old_free <= free_head;
        if (l_act == cllec_pkg::ACT_PUSH || l_act == cllec_pkg::ACT_INS_BELOW ||
            l_act == cllec_pkg::ACT_INS_ABOVE) begin
          if (cllec_pkg::is_node(free_head)) free_head <= free_after;
          else bump <= bump + HW'(1);
          count <= count + HW'(1);
        end
        case (l_act)
          cllec_pkg::ACT_PUSH: begin
            top <= take_h;
            if (!cllec_pkg::is_node(top)) bottom <= take_h;
          end
          cllec_pkg::ACT_INS_BELOW: begin
            if (cur == bottom) bottom <= take_h;
          end
          cllec_pkg::ACT_INS_ABOVE: begin
            if (cur == top) top <= take_h;
          end
          cllec_pkg::ACT_DELETE: begin
            if (xh == top) top <= rd.dn;
            if (xh == bottom) bottom <= rd.up;
            count <= count - HW'(1);
            free_head <= xh;
          end
          default: ;
        endcase
      end
    end
  end

  // memory port schedule: one write per memory in each of the write states WR1 and WR2
  always_comb begin
    req = '0;
    req.data_ra = cur[AW-1:0];
    req.up_ra = xh[AW-1:0];
    req.dn_ra = xh[AW-1:0];
    unique case (state)
      cllec_pkg::S_RD_FREE: req.dn_ra = free_head[AW-1:0];
      cllec_pkg::S_RD_NODE: req.data_ra = xh[AW-1:0];
      cllec_pkg::S_WR1: begin
        case (act)
          cllec_pkg::ACT_PUSH, cllec_pkg::ACT_INS_BELOW, cllec_pkg::ACT_INS_ABOVE: begin
            req.data_we = 1'b1;
            req.data_wa = h_reg;
            req.data_wd = item_data;
            req.dn_we = 1'b1;
            req.dn_wa = h_reg;
            req.up_we = 1'b1;
            req.up_wa = h_reg;
            if (act == cllec_pkg::ACT_PUSH) begin
              req.dn_wd = old_top;
              req.up_wd = cllec_pkg::NONE_H;
            end else if (act == cllec_pkg::ACT_INS_BELOW) begin
              req.dn_wd = dn_reg;
              req.up_wd = {1'b0, c_reg};
            end else begin
              req.dn_wd = {1'b0, c_reg};
              req.up_wd = up_reg;
            end
          end
          cllec_pkg::ACT_DELETE: begin
            req.dn_we = cllec_pkg::is_node(up_reg);
            req.dn_wa = up_reg[AW-1:0];
            req.dn_wd = dn_reg;
            req.up_we = cllec_pkg::is_node(dn_reg);
            req.up_wa = dn_reg[AW-1:0];
            req.up_wd = up_reg;
          end
          default: ;
        endcase
      end
      cllec_pkg::S_WR2: begin
        case (act)
          cllec_pkg::ACT_PUSH: begin
            req.up_we = cllec_pkg::is_node(old_top);
            req.up_wa = old_top[AW-1:0];
            req.up_wd = {1'b0, h_reg};
          end
          cllec_pkg::ACT_INS_BELOW: begin
            req.up_we = cllec_pkg::is_node(dn_reg);
            req.up_wa = dn_reg[AW-1:0];
            req.up_wd = {1'b0, h_reg};
            req.dn_we = 1'b1;
            req.dn_wa = c_reg;
            req.dn_wd = {1'b0, h_reg};
          end
          cllec_pkg::ACT_INS_ABOVE: begin
            req.dn_we = cllec_pkg::is_node(up_reg);
            req.dn_wa = up_reg[AW-1:0];
            req.dn_wd = {1'b0, h_reg};
            req.up_we = 1'b1;
            req.up_wa = c_reg;
            req.up_wd = {1'b0, h_reg};
          end
          cllec_pkg::ACT_DELETE: begin
            // released node joins the free chain and is marked free
            req.dn_we = 1'b1;
            req.dn_wa = c_reg;
            req.dn_wd = old_free;
            req.up_we = 1'b1;
            req.up_wa = c_reg;
            req.up_wd = cllec_pkg::FREE_MARK;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign in_stall = (state != cllec_pkg::S_IDLE);
  assign res_valid = (state == cllec_pkg::S_DONE);

  always_comb begin
    res.status = status_r;
    res.removed_data = removed_r;
    res.cursor_valid = cllec_pkg::is_node(cur);
    res.cursor_handle = cllec_pkg::is_node(cur) ? cur : cllec_pkg::NONE_H;
    res.cursor_data = cllec_pkg::is_node(cur) ? rd.data : '0;
    res.element_count = count;
  end

endmodule

### test/cursor_linked_list_engine_core_checker.sv
`timescale 1ns / 100ps
module cursor_linked_list_engine_core_checker
  import cllec_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending
);

  logic [DATA_W-1:0]   list_data [NODE_DEPTH];
  logic [HANDLE_W-1:0] up_link [NODE_DEPTH];
  logic [HANDLE_W-1:0] dn_link [NODE_DEPTH];
  logic                live [NODE_DEPTH];
  logic [HANDLE_W-1:0] top_h, bot_h, cur_h, n_elem, free_h, fresh_h;
  out_item_t           result_queue [$];

  function automatic logic hnode(logic [HANDLE_W-1:0] h);
    return h < NODE_DEPTH;
  endfunction

  function automatic logic [HANDLE_W-1:0] alloc_node();
    logic [HANDLE_W-1:0] h;
    if (hnode(free_h)) begin
      h = free_h;
      free_h = hnode(dn_link[h[ADDR_W-1:0]]) ? dn_link[h[ADDR_W-1:0]] : NONE_H;
    end else if (fresh_h < NODE_DEPTH) begin
      h = fresh_h;
      fresh_h = fresh_h + HANDLE_W'(1);
    end else begin
      return NONE_H;
    end
    live[h[ADDR_W-1:0]] = 1'b1;
    return h;
  endfunction

  function automatic void free_node(logic [HANDLE_W-1:0] h);
    live[h[ADDR_W-1:0]] = 1'b0;
    dn_link[h[ADDR_W-1:0]] = free_h;
    free_h = h;
  endfunction

  function automatic void stack_on_top(logic [HANDLE_W-1:0] h);
    dn_link[h[ADDR_W-1:0]] = top_h;
    up_link[h[ADDR_W-1:0]] = NONE_H;
    if (hnode(top_h)) up_link[top_h[ADDR_W-1:0]] = h;
    else bot_h = h;
    top_h = h;
    cur_h = h;
    n_elem = n_elem + HANDLE_W'(1);
  endfunction

  function automatic logic [HANDLE_W-1:0] unhook_cursor(logic go_up);
    logic [HANDLE_W-1:0] h, u, d;
    h = cur_h;
    u = up_link[h[ADDR_W-1:0]];
    d = dn_link[h[ADDR_W-1:0]];
    if (hnode(u)) dn_link[u[ADDR_W-1:0]] = d;
    if (hnode(d)) up_link[d[ADDR_W-1:0]] = u;
    cur_h = go_up ? u : d;
    if (h == top_h) top_h = d;
    if (h == bot_h) bot_h = u;
    n_elem = n_elem - HANDLE_W'(1);
    return h;
  endfunction

  function automatic out_item_t apply_op(in_item_t it);
    out_item_t r;
    status_t st;
    logic [HANDLE_W-1:0] h, c, nb;
    logic [DATA_W-1:0] removed;
    st = STAT_OK;
    removed = '0;
    case (it.opcode)
      OP_PUSH: begin
        h = alloc_node();
        if (!hnode(h)) st = STAT_FULL;
        else begin
          list_data[h[ADDR_W-1:0]] = it.item_data;
          stack_on_top(h);
        end
      end
      OP_POP: begin
        cur_h = top_h;
        if (!hnode(cur_h)) st = STAT_NO_ELEM;
        else begin
          h = unhook_cursor(1'b0);
          removed = list_data[h[ADDR_W-1:0]];
          free_node(h);
        end
      end
      OP_TOP: cur_h = top_h;
      OP_BOTTOM: cur_h = bot_h;
      OP_DOWN: if (hnode(cur_h)) cur_h = dn_link[cur_h[ADDR_W-1:0]]; else st = STAT_NO_ELEM;
      OP_UP: if (hnode(cur_h)) cur_h = up_link[cur_h[ADDR_W-1:0]]; else st = STAT_NO_ELEM;
      OP_INS_BELOW, OP_INS_ABOVE: begin
        if (!hnode(cur_h) && hnode(top_h)) st = STAT_POS;
        else begin
          h = alloc_node();
          if (!hnode(h)) st = STAT_FULL;
          else begin
            list_data[h[ADDR_W-1:0]] = it.item_data;
            if (!hnode(cur_h)) stack_on_top(h);
            else begin
              c = cur_h;
              if (it.opcode == OP_INS_BELOW) begin
                nb = dn_link[c[ADDR_W-1:0]];
                dn_link[h[ADDR_W-1:0]] = nb;
                up_link[h[ADDR_W-1:0]] = c;
                if (hnode(nb)) up_link[nb[ADDR_W-1:0]] = h;
                dn_link[c[ADDR_W-1:0]] = h;
                if (c == bot_h) bot_h = h;
              end else begin
                nb = up_link[c[ADDR_W-1:0]];
                dn_link[h[ADDR_W-1:0]] = c;
                up_link[h[ADDR_W-1:0]] = nb;
                if (hnode(nb)) dn_link[nb[ADDR_W-1:0]] = h;
                up_link[c[ADDR_W-1:0]] = h;
                if (c == top_h) top_h = h;
              end
              n_elem = n_elem + HANDLE_W'(1);
              cur_h = h;
            end
          end
        end
      end
      OP_DELETE: begin
        if (!hnode(cur_h)) st = STAT_NO_ELEM;
        else begin
          h = unhook_cursor(it.move_up_after);
          removed = list_data[h[ADDR_W-1:0]];
          free_node(h);
        end
      end
      OP_GOTO: begin
        if (!hnode(it.target_handle)) cur_h = NONE_H;
        else if (live[it.target_handle[ADDR_W-1:0]]) cur_h = it.target_handle;
        else begin
          cur_h = NONE_H;
          st = STAT_NO_ELEM;
        end
      end
      default: ;
    endcase
    r.status = st;
    r.removed_data = removed;
    r.cursor_valid = hnode(cur_h);
    r.cursor_handle = hnode(cur_h) ? cur_h : NONE_H;
    r.cursor_data = hnode(cur_h) ? list_data[cur_h[ADDR_W-1:0]] : '0;
    r.element_count = n_elem;
    return r;
  endfunction

  assign pending = result_queue.size();

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      for (int i = 0; i < NODE_DEPTH; i++) begin
        live[i] = 1'b0;
        list_data[i] = '0;
        up_link[i] = '0;
        dn_link[i] = '0;
      end
      top_h = NONE_H;
      bot_h = NONE_H;
      cur_h = NONE_H;
      free_h = NONE_H;
      n_elem = '0;
      fresh_h = '0;
      result_queue.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (result_queue.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result item %p", out_item);
        end else begin
          want = result_queue.pop_front();
          if (want !== out_item) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) $display("result mismatch: expected %p actual %p", want, out_item);
          end
        end
      end
      if (in_valid && !in_stall) result_queue.push_back(apply_op(in_item));
    end
  end

endmodule

### test/cursor_linked_list_engine_core_tb.sv
`timescale 1ns / 100ps
module cursor_linked_list_engine_core_tb;
  import cllec_pkg::*;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  int        fail_count;
  int        pending;
  int        quiet_cycles;
  bit        hold_off;

  localparam int QUIET_LIMIT = 20000;

  cursor_linked_list_engine_core dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  cursor_linked_list_engine_core_checker checker_i (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // valid stays high after acceptance until the next item or an idle gap replaces it
  task automatic send_op(logic [3:0] op, logic [DATA_W-1:0] d, logic up,
                         logic [HANDLE_W-1:0] tgt);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{opcode: op, item_data: d, move_up_after: up, target_handle: tgt};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random();
    int pick;
    logic [3:0] op;
    logic [HANDLE_W-1:0] tgt;
    pick = $urandom_range(0, 99);
    if (pick < 30) op = OP_PUSH;
    else if (pick < 40) op = OP_POP;
    else if (pick < 96) op = 4'($urandom_range(2, 9));
    else op = 4'($urandom_range(10, 15));
    tgt = $urandom_range(0, 9) == 0 ? HANDLE_W'($urandom_range(256, 511))
                                    : HANDLE_W'($urandom_range(0, 40));
    send_op(op, $urandom, 1'($urandom), tgt);
  endtask

  // receiver stall, with one long hold-off
  initial begin
    int gap;
    out_stall <= 1'b1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("cursor_linked_list_engine_core verification failed");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_item <= '0;
    hold_off = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // empty-list corner cases, then cursor and goto cases on a short list
    send_op(OP_POP, '0, 1'b0, '0);
    send_op(OP_UP, '0, 1'b0, '0);
    send_op(OP_DOWN, '0, 1'b0, '0);
    send_op(OP_TOP, '0, 1'b0, '0);
    send_op(OP_BOTTOM, '0, 1'b0, '0);
    send_op(OP_DELETE, '0, 1'b1, '0);
    send_op(OP_GOTO, '0, 1'b0, 9'd0);
    send_op(OP_INS_BELOW, 32'hFFFF_FFFF, 1'b0, '0);
    send_op(OP_PUSH, '0, 1'b0, 9'h1FF);
    send_op(OP_INS_ABOVE, 32'hA5A5_5A5A, 1'b0, '0);
    send_op(OP_INS_BELOW, 32'h5A5A_A5A5, 1'b0, '0);
    send_op(OP_GOTO, '0, 1'b0, NONE_H);
    send_op(OP_INS_ABOVE, 32'h1, 1'b0, '0);
    send_op(OP_BOTTOM, '0, 1'b0, '0);
    send_op(OP_DOWN, '0, 1'b0, '0);
    send_op(OP_TOP, '0, 1'b0, '0);
    send_op(OP_UP, '0, 1'b0, '0);
    send_op(OP_GOTO, '0, 1'b0, 9'd1);
    send_op(OP_DELETE, '0, 1'b1, '0);
    send_op(OP_GOTO, '0, 1'b0, 9'd1);
    send_op(OP_GOTO, '0, 1'b0, 9'h1FF);
    send_op(4'd15, 32'hFFFF_FFFF, 1'b1, 9'h1FF);
    send_op(OP_POP, '0, 1'b0, '0);
    // let results back up into the engine
    hold_off = 1'b1;
    for (int i = 0; i < 20; i++) send_random();
    // wait for the engine to drain
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int i = 0; i < 60; i++) send_random();
    // fill the pool to exercise the full case
    for (int i = 0; i < 270; i++) send_op(OP_PUSH, $urandom, 1'b0, '0);
    send_op(OP_INS_BELOW, $urandom, 1'b0, '0);
    send_op(OP_GOTO, '0, 1'b0, NONE_H);
    send_op(OP_INS_ABOVE, $urandom, 1'b0, '0);
    send_op(OP_GOTO, '0, 1'b0, 9'd255);
    for (int i = 0; i < 30; i++) send_random();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("cursor_linked_list_engine_core verification clean");
    else $display("cursor_linked_list_engine_core verification failed");
    $finish;
  end

endmodule

### cursor_linked_list_engine_core.f
+incdir+rtl/core
rtl/core/cllec_pkg.sv
rtl/core/cllec_node_mem.sv
rtl/core/cllec_ctrl.sv
rtl/core/cursor_linked_list_engine_core.sv
test/cursor_linked_list_engine_core_checker.sv
test/cursor_linked_list_engine_core_tb.sv
